[rtl/sspc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types, constants and the multiply program of the swept sphere
// pair collision test.
// ----------------------------------------------------------------------------
package sspc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MARGIN_RAW = (1 << FRAC_BITS) / 100;
  localparam logic [15:0] MARGIN_RST = (MARGIN_RAW > 65535) ? 16'hFFFF : 16'(MARGIN_RAW);

  localparam int POSW  = 32;   // position width
  localparam int RADW  = 24;   // radius width
  localparam int MARW  = 16;   // margin width
  localparam int VW    = 34;   // d, b0, v vectors
  localparam int RSW   = 26;   // widened radius sum
  localparam int OPW   = 72;   // signed multiplier operand
  localparam int ACCW  = 2 * OPW + 2;
  localparam int CNTW  = $clog2(OPW + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int NUM_OPS = 23;
  localparam int STEPW   = $clog2(NUM_OPS);

  typedef enum logic [1:0] {
    PATH_BOX    = 2'd0,
    PATH_SWEPT  = 2'd1,
    PATH_STATIC = 2'd2
  } path_e;

  typedef enum logic [3:0] {
    OPD_D0, OPD_D1, OPD_D2,
    OPD_V0, OPD_V1, OPD_V2,
    OPD_B0, OPD_B1, OPD_B2,
    OPD_RS, OPD_CC, OPD_R2, OPD_LV
  } opnd_e;

  typedef enum logic [2:0] {
    ACC_DD = 3'd0,
    ACC_LV = 3'd1,
    ACC_DT = 3'd2,
    ACC_BB = 3'd3,
    ACC_R2 = 3'd4,
    ACC_CC = 3'd5,
    ACC_CR = 3'd6,
    ACC_RL = 3'd7
  } acc_e;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_LOAD
  } mode_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    acc_e  dst;
    mode_e mode;
  } mop_t;

  typedef struct packed {
    logic                  apart;
    logic signed [VW-1:0]  d0;
    logic signed [VW-1:0]  d1;
    logic signed [VW-1:0]  d2;
    logic signed [VW-1:0]  v0;
    logic signed [VW-1:0]  v1;
    logic signed [VW-1:0]  v2;
    logic signed [VW-1:0]  b0;
    logic signed [VW-1:0]  b1;
    logic signed [VW-1:0]  b2;
    logic        [RSW-1:0] rs;
  } job_t;

  function automatic mop_t mk(opnd_e a, opnd_e b, acc_e dst, mode_e mode);
    mop_t m;
    m.a    = a;
    m.b    = b;
    m.dst  = dst;
    m.mode = mode;
    return m;
  endfunction

  // Multiply program: dot products, radius square, cross length, r2 * lv.
  function automatic mop_t mop_of(logic [STEPW-1:0] step);
    mop_t m;
    unique case (step)
      5'd0:    m = mk(OPD_D0, OPD_D0, ACC_DD, MODE_ADD);
      5'd1:    m = mk(OPD_D1, OPD_D1, ACC_DD, MODE_ADD);
      5'd2:    m = mk(OPD_D2, OPD_D2, ACC_DD, MODE_ADD);
      5'd3:    m = mk(OPD_V0, OPD_V0, ACC_LV, MODE_ADD);
      5'd4:    m = mk(OPD_V1, OPD_V1, ACC_LV, MODE_ADD);
      5'd5:    m = mk(OPD_V2, OPD_V2, ACC_LV, MODE_ADD);
      5'd6:    m = mk(OPD_B0, OPD_V0, ACC_DT, MODE_ADD);
      5'd7:    m = mk(OPD_B1, OPD_V1, ACC_DT, MODE_ADD);
      5'd8:    m = mk(OPD_B2, OPD_V2, ACC_DT, MODE_ADD);
      5'd9:    m = mk(OPD_B0, OPD_B0, ACC_BB, MODE_ADD);
      5'd10:   m = mk(OPD_B1, OPD_B1, ACC_BB, MODE_ADD);
      5'd11:   m = mk(OPD_B2, OPD_B2, ACC_BB, MODE_ADD);
      5'd12:   m = mk(OPD_RS, OPD_RS, ACC_R2, MODE_LOAD);
      5'd13:   m = mk(OPD_B1, OPD_V2, ACC_CC, MODE_LOAD);
      5'd14:   m = mk(OPD_B2, OPD_V1, ACC_CC, MODE_SUB);
      5'd15:   m = mk(OPD_CC, OPD_CC, ACC_CR, MODE_ADD);
      5'd16:   m = mk(OPD_B2, OPD_V0, ACC_CC, MODE_LOAD);
      5'd17:   m = mk(OPD_B0, OPD_V2, ACC_CC, MODE_SUB);
      5'd18:   m = mk(OPD_CC, OPD_CC, ACC_CR, MODE_ADD);
      5'd19:   m = mk(OPD_B0, OPD_V1, ACC_CC, MODE_LOAD);
      5'd20:   m = mk(OPD_B1, OPD_V0, ACC_CC, MODE_SUB);
      5'd21:   m = mk(OPD_CC, OPD_CC, ACC_CR, MODE_ADD);
      5'd22:   m = mk(OPD_R2, OPD_LV, ACC_RL, MODE_LOAD);
      default: m = mk(OPD_D0, OPD_D0, ACC_DD, MODE_ADD);
    endcase
    return m;
  endfunction

endpackage

[rtl/sspc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspc_front
// Accepts sphere items, holds sphere A and the margin register, and turns
// each sphere B into a job with the difference vectors and the box verdict.
// ----------------------------------------------------------------------------
module sspc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_role_i,
  input  logic [215:0]         in_data_i,
  output logic                 in_ready_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sspc_pkg::job_t       q_job_o
);
  import sspc_pkg::*;

  logic [MARW-1:0]        margin_q;
  logic signed [POSW-1:0] a_pos_q [3];
  logic signed [POSW-1:0] a_prev_q [3];
  logic [RADW-1:0]        a_rad_q;

  logic signed [POSW-1:0] b_pos [3];
  logic signed [POSW-1:0] b_prev [3];
  logic [RADW-1:0]        b_rad;
  logic signed [VW-1:0]   d [3];
  logic signed [VW-1:0]   b0 [3];
  logic signed [VW-1:0]   v [3];
  logic [RSW-1:0]         rs;
  logic signed [VW-1:0]   rs_s;
  logic [2:0]             apart;
  logic                   accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && in_role_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_pos[i]  = $signed(in_data_i[POSW*i +: POSW]);
      b_prev[i] = $signed(in_data_i[POSW*(3+i) +: POSW]);
      d[i]      = VW'(b_pos[i]) - VW'(a_pos_q[i]);
      b0[i]     = VW'(b_prev[i]) - VW'(a_prev_q[i]);
      v[i]      = d[i] - b0[i];
    end
    b_rad = in_data_i[6*POSW +: RADW];
    rs    = RSW'(a_rad_q) + RSW'(b_rad) + RSW'({margin_q, 1'b0});
    rs_s  = $signed({{(VW-RSW){1'b0}}, rs});
    // Boxes apart on an axis: both ends of the step lie beyond the radius sum.
    for (int i = 0; i < 3; i++) begin
      apart[i] = (d[i] > rs_s && b0[i] > rs_s) || (d[i] < -rs_s && b0[i] < -rs_s);
    end
    q_job_o.apart = |apart;
    q_job_o.d0 = d[0];
    q_job_o.d1 = d[1];
    q_job_o.d2 = d[2];
    q_job_o.v0 = v[0];
    q_job_o.v1 = v[1];
    q_job_o.v2 = v[2];
    q_job_o.b0 = b0[0];
    q_job_o.b1 = b0[1];
    q_job_o.b2 = b0[2];
    q_job_o.rs = rs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RST;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_role_i) begin
      for (int i = 0; i < 3; i++) begin
        a_pos_q[i]  <= b_pos[i];
        a_prev_q[i] <= b_prev[i];
      end
      a_rad_q <= b_rad;
    end
  end

endmodule

[rtl/sspc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspc_fifo
// Short job queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module sspc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sspc_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sspc_pkg::job_t pop_job_o
);
  import sspc_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o    = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

[rtl/sspc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspc_back
// Runs the multiply program of a job that is not box rejected on a shift-add
// multiplier; decides hit and test path; result held in an output register.
// ----------------------------------------------------------------------------
module sspc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  sspc_pkg::job_t q_job_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_hit_o,
  output logic [1:0]     out_path_o
);
  import sspc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [STEPW-1:0]       step_q;
  logic [CNTW-1:0]        cnt_q;
  job_t                   job_q;
  logic signed [ACCW-1:0] acc_q [8];
  logic [OPW-1:0]         mcand_q;
  logic [2*OPW-1:0]       prod_q;
  logic                   neg_q;
  logic                   out_valid_q, hit_q;
  path_e                  path_q;

  mop_t                   mop;
  logic signed [OPW-1:0]  opa, opb;
  logic [OPW:0]           psum;
  logic signed [ACCW-1:0] sprod;
  logic                   zero_v, res_hit;
  path_e                  res_path;

  function automatic logic signed [OPW-1:0] pick(opnd_e sel, job_t j,
                                                 logic signed [ACCW-1:0] cc,
                                                 logic signed [ACCW-1:0] r2,
                                                 logic signed [ACCW-1:0] lv);
    logic signed [OPW-1:0] r;
    unique case (sel)
      OPD_D0:  r = OPW'(j.d0);
      OPD_D1:  r = OPW'(j.d1);
      OPD_D2:  r = OPW'(j.d2);
      OPD_V0:  r = OPW'(j.v0);
      OPD_V1:  r = OPW'(j.v1);
      OPD_V2:  r = OPW'(j.v2);
      OPD_B0:  r = OPW'(j.b0);
      OPD_B1:  r = OPW'(j.b1);
      OPD_B2:  r = OPW'(j.b2);
      OPD_RS:  r = $signed({{(OPW-RSW){1'b0}}, j.rs});
      OPD_CC:  r = $signed(cc[OPW-1:0]);
      OPD_R2:  r = $signed(r2[OPW-1:0]);
      OPD_LV:  r = $signed(lv[OPW-1:0]);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign mop     = mop_of(step_q);
  assign opa     = pick(mop.a, job_q, acc_q[ACC_CC], acc_q[ACC_R2], acc_q[ACC_LV]);
  assign opb     = pick(mop.b, job_q, acc_q[ACC_CC], acc_q[ACC_R2], acc_q[ACC_LV]);
  assign psum    = {1'b0, prod_q[2*OPW-1:OPW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign sprod   = neg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = hit_q;
  assign out_path_o  = path_q;

  always_comb begin
    zero_v = (job_q.v0 == '0) && (job_q.v1 == '0) && (job_q.v2 == '0);
    if (job_q.apart) begin
      res_hit  = 1'b0;
      res_path = PATH_BOX;
    end else if (zero_v) begin
      res_hit  = acc_q[ACC_DD] < acc_q[ACC_R2];
      res_path = PATH_STATIC;
    end else begin
      res_path = PATH_SWEPT;
      if (!acc_q[ACC_DT][ACCW-1]) begin
        res_hit = acc_q[ACC_BB] < acc_q[ACC_R2];
      end else if (!(-acc_q[ACC_DT] < acc_q[ACC_LV])) begin
        res_hit = acc_q[ACC_DD] < acc_q[ACC_R2];
      end else begin
        res_hit = acc_q[ACC_CR] < acc_q[ACC_RL];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      path_q      <= PATH_BOX;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            step_q  <= '0;
            state_q <= q_job_i.apart ? ST_DONE : ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(OPW - 1)) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (step_q == STEPW'(NUM_OPS - 1)) begin
            state_q <= ST_DONE;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            hit_q   <= res_hit;
            path_q  <= res_path;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
      for (int i = 0; i < 8; i++) begin
        acc_q[i] <= '0;
      end
    end
    if (state_q == ST_LOAD) begin
      neg_q   <= opa[OPW-1] ^ opb[OPW-1];
      mcand_q <= opa[OPW-1] ? OPW'(-opa) : OPW'(opa);
      prod_q  <= {{OPW{1'b0}}, (opb[OPW-1] ? OPW'(-opb) : OPW'(opb))};
    end
    if (state_q == ST_MUL) begin
      prod_q <= {psum, prod_q[OPW-1:1]};
    end
    if (state_q == ST_ACC) begin
      case (mop.mode)
        MODE_ADD:  acc_q[mop.dst] <= acc_q[mop.dst] + sprod;
        MODE_SUB:  acc_q[mop.dst] <= acc_q[mop.dst] - sprod;
        default:   acc_q[mop.dst] <= sprod;
      endcase
    end
  end

endmodule

[rtl/swept_sphere_pair_collision_test_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_sphere_pair_collision_test_top
// Continuous sphere-sphere collision test of each sphere B against sphere A.
// ----------------------------------------------------------------------------
// Flow: a box-rejected pair skips the multiplier, going from the queue
// via the done state to the output register; a full test runs 23 multiplies.
// Throughput: one pair test at a time in the shift-add multiplier; sphere A
// items and up to two queued pairs are taken meanwhile if the queue has room.
// Reset clears control state and sets the contact margin to 655.

module swept_sphere_pair_collision_test_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, prev_x, prev_y, prev_z, sphere_radius
  input  logic [215:0] s_axis_tdata,
  // pair_role
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, zero fill
  output logic [7:0]   m_axis_tdata,
  // test_path
  output logic [1:0]   m_axis_tuser
);
  import sspc_pkg::*;

  logic q_full, q_push, q_empty, q_pop, hit;
  job_t push_job, pop_job;

  sspc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_role_i   (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  sspc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_job_o  (pop_job)
  );

  sspc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (hit),
    .out_path_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, hit};

endmodule

[dv/tb_swept_sphere_pair_collision_test_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swept_sphere_pair_collision_test_top
// Drives sphere A / sphere B transfers into the swept sphere pair collision
// test and checks every hit flag and test path. The checks come from an
// exact wide-integer predictor of the box reject, static overlap and swept
// closest-approach tests. Both stream sides idle at random, and the receiver
// holds off once for a long stretch. The contact margin is swept through
// several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb_swept_sphere_pair_collision_test_top;
  import sspc_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 1120;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    longint px, py, pz, qx, qy, qz, r;
  } sphere_t;

  typedef struct {
    logic  hit;
    path_e path;
  } collision_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  collision_t expected_collisions[$];
  sphere_t    held_a;
  longint     margin;
  int         errors;
  int         items_sent;
  int         hold_left;
  bit         sender_idles;
  bit         receiver_idles;
  int         quiet_cycles;

  swept_sphere_pair_collision_test_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic wide_t wd(longint x);
    return wide_t'(x);
  endfunction

  function automatic wide_t dot3(longint a0, longint a1, longint a2,
                                 longint b0, longint b1, longint b2);
    return wd(a0) * wd(b0) + wd(a1) * wd(b1) + wd(a2) * wd(b2);
  endfunction

  // Exact continuous test of sphere b against the held sphere A.
  function automatic collision_t predict_collision(sphere_t b);
    collision_t res;
    longint ra, rb, ap[3], aq[3], bp[3], bq[3], v[3], s[3], d[3];
    wide_t r2, lv, dt, c, cr;
    bit apart;
    ra = held_a.r + margin;
    rb = b.r + margin;
    ap = '{held_a.px, held_a.py, held_a.pz};
    aq = '{held_a.qx, held_a.qy, held_a.qz};
    bp = '{b.px, b.py, b.pz};
    bq = '{b.qx, b.qy, b.qz};
    apart = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((ap[i] + ra < bp[i] - rb && aq[i] + ra < bq[i] - rb) ||
          (ap[i] - ra > bp[i] + rb && aq[i] - ra > bq[i] + rb))
        apart = 1'b1;
      v[i] = (bp[i] - bq[i]) - (ap[i] - aq[i]);
      s[i] = bq[i] - aq[i];
      d[i] = bp[i] - ap[i];
    end
    if (apart) begin
      res.hit  = 1'b0;
      res.path = PATH_BOX;
      return res;
    end
    r2 = wd(ra + rb) * wd(ra + rb);
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
      res.hit  = dot3(d[0], d[1], d[2], d[0], d[1], d[2]) < r2;
      res.path = PATH_STATIC;
      return res;
    end
    lv = dot3(v[0], v[1], v[2], v[0], v[1], v[2]);
    dt = dot3(s[0], s[1], s[2], v[0], v[1], v[2]);
    if (dt >= 0) begin
      res.hit = dot3(s[0], s[1], s[2], s[0], s[1], s[2]) < r2;
    end else if (-dt >= lv) begin
      res.hit = dot3(d[0], d[1], d[2], d[0], d[1], d[2]) < r2;
    end else begin
      cr = 0;
      for (int i = 0; i < 3; i++) begin
        c  = wd(s[(i + 1) % 3]) * wd(v[(i + 2) % 3]) -
             wd(s[(i + 2) % 3]) * wd(v[(i + 1) % 3]);
        cr = cr + c * c;
      end
      res.hit = cr < r2 * lv;
    end
    res.path = PATH_SWEPT;
    return res;
  endfunction

  function automatic sphere_t mk_sphere(longint px, longint py, longint pz,
                                        longint qx, longint qy, longint qz,
                                        longint r);
    sphere_t s;
    s = '{px, py, pz, qx, qy, qz, r};
    return s;
  endfunction

  // Hold valid across back-to-back transfers; drop it only for idle gaps.
  task automatic send_sphere(bit role, sphere_t s);
    collision_t res;
    @(negedge clk_i);
    if (sender_idles && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= role;
    s_axis_tdata  <= {s.r[23:0], s.qz[31:0], s.qy[31:0], s.qx[31:0],
                      s.pz[31:0], s.py[31:0], s.px[31:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (role == 1'b0) begin
      held_a = s;
    end else begin
      res = predict_collision(s);
      expected_collisions.insert(expected_collisions.size(), res);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    wait (expected_collisions.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [15:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    margin = value;
  endtask

  function automatic longint rand_pos();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint near(longint base, int span);
    longint x;
    x = base + longint'($urandom_range(0, 2 * span)) - span;
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x;
  endfunction

  function automatic sphere_t rand_full();
    return mk_sphere(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                     rand_pos(), longint'($urandom_range(0, 24'hFFFFFF)));
  endfunction

  // Sphere around a center; moves or stays put, small or large radius.
  function automatic sphere_t rand_near(longint cx, longint cy, longint cz);
    sphere_t s;
    int span;
    span = ($urandom_range(0, 3) == 0) ? (1 << 22) : (1 << 18);
    s.px = near(cx, span);
    s.py = near(cy, span);
    s.pz = near(cz, span);
    if ($urandom_range(0, 3) == 0) begin
      s.qx = s.px;
      s.qy = s.py;
      s.qz = s.pz;
    end else begin
      s.qx = near(s.px, span);
      s.qy = near(s.py, span);
      s.qz = near(s.pz, span);
    end
    s.r = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 24'hFFFFFF))
                                     : longint'($urandom_range(0, 1 << 18));
    return s;
  endfunction

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // Touching at exactly the widened radius sum is no hit; one unit closer is.
    send_sphere(1'b0, mk_sphere(0, 0, 0, 0, 0, 0, 0));
    send_sphere(1'b1, mk_sphere(2 * margin, 0, 0, 2 * margin, 0, 0, 0));
    send_sphere(1'b1, mk_sphere(2 * margin - 1, 0, 0, 2 * margin - 1, 0, 0, 0));
    send_sphere(1'b1, mk_sphere(0, 0, 0, 0, 0, 0, 0));
    // Extremes of every field, box rejected and not.
    send_sphere(1'b0, mk_sphere(mx, mx, mx, mx, mx, mx, 24'hFFFFFF));
    send_sphere(1'b1, mk_sphere(mn, mn, mn, mn, mn, mn, 24'hFFFFFF));
    send_sphere(1'b1, mk_sphere(mx, mx, mx, mn, mn, mn, 24'hFFFFFF));
    send_sphere(1'b1, mk_sphere(mn, mn, mn, mx, mx, mx, 0));
    send_sphere(1'b0, mk_sphere(mn, mx, mn, mx, mn, mx, 0));
    send_sphere(1'b1, mk_sphere(mx, mn, mx, mn, mx, mn, 24'hFFFFFF));
    // Pass-through during the step: closest approach strictly inside 0..1.
    send_sphere(1'b0, mk_sphere(0, 0, 0, 0, 0, 0, 65536));
    send_sphere(1'b1, mk_sphere(-400000, 1000, 0, 400000, 1000, 0, 65536));
    send_sphere(1'b1, mk_sphere(-400000, 200000, 0, 400000, 200000, 0, 65536));
    // Closest approach clamped to the previous step and to the current step.
    send_sphere(1'b1, mk_sphere(900000, 0, 0, 100000, 0, 0, 65536));
    send_sphere(1'b1, mk_sphere(100000, 0, 0, 900000, 0, 0, 65536));
    send_sphere(1'b1, mk_sphere(300000, 0, 0, 900000, 0, 0, 65536));
    // Both moving together: zero relative motion takes the static path.
    send_sphere(1'b0, mk_sphere(500000, 0, 0, 0, 0, 0, 1000));
    send_sphere(1'b1, mk_sphere(510000, 0, 0, 10000, 0, 0, 1000));
    send_sphere(1'b1, mk_sphere(500000, 90000, 0, 0, 90000, 0, 1000));
    // A overwritten by a second A before the test.
    send_sphere(1'b0, mk_sphere(7, 7, 7, 7, 7, 7, 7));
    send_sphere(1'b1, mk_sphere(7, 7, 7, 7, 7, 7, 7));
    drain();
  endtask

  task automatic test_margin_sweep();
    logic [15:0] settings[4];
    settings = '{16'd0, 16'hFFFF, 16'(MARGIN_RST), 16'($urandom_range(0, 65535))};
    foreach (settings[k]) begin
      write_margin(settings[k]);
      send_sphere(1'b0, mk_sphere(0, 0, 0, 0, 0, 0, 0));
      send_sphere(1'b1, mk_sphere(2 * margin, 0, 0, 2 * margin, 0, 0, 0));
      send_sphere(1'b1, mk_sphere(2 * margin - 1, 0, 0, 2 * margin - 1, 0, 0, 0));
      send_sphere(1'b1, mk_sphere(0, 2 * margin + 5, 0, 0, -2 * margin - 5, 0, 0));
    end
  endtask

  task automatic test_backpressure();
    longint cx;
    cx = rand_pos() / 2;
    hold_left = 6000;
    for (int k = 0; k < 8; k++) begin
      send_sphere(1'b0, rand_near(cx, 0, 0));
      send_sphere(1'b1, rand_near(cx, 0, 0));
    end
    drain();
  endtask

  task automatic test_random_pairs();
    longint cx, cy, cz;
    sphere_t s;
    int n_b;
    while (items_sent < RANDOM_ITEMS) begin
      sender_idles   = (items_sent % 400) < 300;
      receiver_idles = sender_idles;
      if ((items_sent % 300) < 4 && items_sent > 200)
        write_margin(16'($urandom_range(0, 65535)));
      cx = rand_pos() / 2;
      cy = rand_pos() / 2;
      cz = rand_pos() / 2;
      if ($urandom_range(0, 9) == 0) begin
        // Noise: fully random spheres, mostly box rejected.
        send_sphere(1'($urandom_range(0, 1)), rand_full());
      end else begin
        if ($urandom_range(0, 9) == 0) send_sphere(1'b0, rand_near(cx, cy, cz));
        send_sphere(1'b0, rand_near(cx, cy, cz));
        n_b = $urandom_range(1, 3);
        for (int k = 0; k < n_b; k++) begin
          s = ($urandom_range(0, 4) == 0) ? rand_full() : rand_near(cx, cy, cz);
          send_sphere(1'b1, s);
        end
      end
    end
    drain();
  endtask

  // Receiver: random stalls, plus a counted hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(receiver_idles && $urandom_range(0, 99) < 10);
      end
    end
  end

  always @(posedge clk_i) begin
    collision_t exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_collisions.size() == 0) begin
        $error("result transfer with no pending expectation");
        errors++;
      end else begin
        exp_res = expected_collisions.pop_front();
        if (m_axis_tdata[0] !== exp_res.hit) begin
          $error("hit: expected %0b, actual %0b", exp_res.hit, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tuser !== exp_res.path) begin
          $error("test_path: expected %0d, actual %0d", exp_res.path, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_swept_sphere_pair_collision_test_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    errors         = 0;
    items_sent     = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    margin         = MARGIN_RST;
    held_a         = mk_sphere(0, 0, 0, 0, 0, 0, 0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_margin_sweep();
    test_backpressure();
    test_random_pairs();

    if (errors == 0 && expected_collisions.size() == 0) begin
      $display("tb_swept_sphere_pair_collision_test_top: PASS");
    end else begin
      $display("tb_swept_sphere_pair_collision_test_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sspc_pkg.sv
rtl/sspc_front.sv
rtl/sspc_fifo.sv
rtl/sspc_back.sv
rtl/swept_sphere_pair_collision_test_top.sv
dv/tb_swept_sphere_pair_collision_test_top.sv
